/* rtl/iopb_pkg.sv */
`timescale 1ns / 1ps
package iopb_pkg;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_KEY   = 2'd2
	} mode_t;

	// port bits 7..5 select the group
	localparam logic [2:0] GRP_LATCH  = 3'b111;
	localparam logic [2:0] GRP_SERIAL = 3'b110;
	localparam logic [2:0] GRP_IDE    = 3'b101;

	localparam logic [15:0] DBG_PORT_LO = 16'h00FD;
	localparam logic [15:0] DBG_PORT_HI = 16'h00FF;

	localparam logic [1:0] SER_A_DATA = 2'd0;
	localparam logic [1:0] SER_A_CTRL = 2'd1;
	localparam logic [1:0] SER_B_DATA = 2'd2;
	localparam logic [1:0] SER_B_CTRL = 2'd3;

	localparam logic [2:0] IDE_DATA   = 3'd0;
	localparam logic [2:0] IDE_LBA0   = 3'd3;
	localparam logic [2:0] IDE_LBA1   = 3'd4;
	localparam logic [2:0] IDE_LBA2   = 3'd5;
	localparam logic [2:0] IDE_LBA3   = 3'd6;
	localparam logic [2:0] IDE_CMD    = 3'd7;

	localparam logic [7:0] IDE_STATUS_READY = 8'h48;
	localparam logic [7:0] IDE_CMD_READ     = 8'h20;
	localparam logic [7:0] KEY_LIMIT        = 8'h80;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] data;
	} kfifo_ctrl_t;

endpackage

/* rtl/iopb_kfifo.sv */
`timescale 1ns / 1ps
module iopb_kfifo #(
	parameter int KEY_FIFO_DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  iopb_pkg::kfifo_ctrl_t                    ctrl,
	output logic [7:0]                               head,
	output logic [$clog2(KEY_FIFO_DEPTH + 1) - 1:0]  level
);
	import iopb_pkg::*;

	localparam int AW = (KEY_FIFO_DEPTH > 1) ? $clog2(KEY_FIFO_DEPTH) : 1;
	localparam int LW = $clog2(KEY_FIFO_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(KEY_FIFO_DEPTH - 1);
	localparam logic [LW-1:0] FULL = LW'(KEY_FIFO_DEPTH);

	logic [7:0]    mem [KEY_FIFO_DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW-1:0] rptr_next;
	logic [LW-1:0] level_q;
	logic [7:0]    rd_q;
	logic          byp_q;
	logic [7:0]    byp_data_q;

	assign rptr_next = ctrl.pop ? ((rptr_q == LAST) ? '0 : rptr_q + 1'b1) : rptr_q;

	// storage, read port prefetches the head for the next request
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wptr_q] <= ctrl.data;
		end
		rd_q       <= mem[rptr_next];
		byp_data_q <= ctrl.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
			byp_q   <= 1'b0;
		end else begin
			rptr_q <= rptr_next;
			// push into an empty fifo: head comes from the write, not the array
			byp_q  <= ctrl.push && (wptr_q == rptr_next);
			if (ctrl.push) begin
				wptr_q  <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
				level_q <= level_q + 1'b1;
			end else if (ctrl.pop) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign head  = byp_q ? byp_data_q : rd_q;
	assign level = level_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= FULL)
		else $error("fifo level beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> level_q != FULL)
		else $error("push into full fifo");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> level_q != '0 && !ctrl.push)
		else $error("bad pop");

endmodule

/* rtl/io_port_block_with_key_fifo.sv */
`timescale 1ns / 1ps
// Pipeline: input register, then result register, between request accept and result valid.
// Throughput: 1 request per cycle unless m_tready stalls; the key fifo read port prefetches the head each cycle.
// Result register is released by m_tready; stall propagates combinationally to s_tready.
// Reset: arst_n asynchronous, active low; clears pointers, fifo level, LBA, latch.
// Key fifo contents are not cleared; entries are only read after being written.
module io_port_block_with_key_fifo #(
	parameter int KEY_FIFO_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] port, [23:16] write_byte, [31:24] key_code, [39:32] disk_byte
	input  logic [39:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] read_byte, [8] map_select, [14:9] display_mode, [42:15] sector_address,
	// [43] sector_read_request, [52:44] keys_waiting, [55:53] zero
	output logic [55:0] m_tdata
);
	import iopb_pkg::*;

	localparam int LW = $clog2(KEY_FIFO_DEPTH + 1);
	localparam logic [LW-1:0] FULL = LW'(KEY_FIFO_DEPTH);

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [15:0] port_s1;
	logic [7:0]  wb_s1;
	logic [7:0]  key_s1;
	logic [7:0]  disk_s1;

	logic        out_v_q;
	logic [55:0] out_q;

	logic [2:0]  cha_ptr_q, cha_ptr_d;
	logic [2:0]  chb_ptr_q, chb_ptr_d;
	logic [27:0] lba_q, lba_d;
	logic        bank_q, bank_d;
	logic [5:0]  vmode_q, vmode_d;
	logic [7:0]  rd;
	logic        req;
	logic        step;

	kfifo_ctrl_t   fctrl;
	logic [7:0]    fhead;
	logic [LW-1:0] flevel;
	logic [LW-1:0] level_after;
	logic [LW+8:0] level_ext;

	assign step     = valid_s1 && (!out_v_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			port_s1 <= s_tdata[15:0];
			wb_s1   <= s_tdata[23:16];
			key_s1  <= s_tdata[31:24];
			disk_s1 <= s_tdata[39:32];
		end
	end

	always_comb begin
		cha_ptr_d  = cha_ptr_q;
		chb_ptr_d  = chb_ptr_q;
		lba_d      = lba_q;
		bank_d     = bank_q;
		vmode_d    = vmode_q;
		rd         = 8'h00;
		req        = 1'b0;
		fctrl.push = 1'b0;
		fctrl.pop  = 1'b0;
		fctrl.data = key_s1;
		unique case (mode_s1)
			MODE_WRITE: begin
				if (port_s1[7:5] == GRP_LATCH) begin
					if (port_s1 < DBG_PORT_LO || port_s1 > DBG_PORT_HI) begin
						bank_d  = wb_s1[3];
						vmode_d = {wb_s1[1], 1'b0, wb_s1[0], wb_s1[6:4]};
					end
				end else if (port_s1[7:5] == GRP_SERIAL) begin
					unique case (port_s1[1:0])
						SER_A_DATA: cha_ptr_d = '0;
						SER_A_CTRL: cha_ptr_d = wb_s1[2:0];
						SER_B_DATA: chb_ptr_d = '0;
						SER_B_CTRL: chb_ptr_d = wb_s1[2:0];
						default: ;
					endcase
				end else if (port_s1[7:5] == GRP_IDE) begin
					unique case (port_s1[2:0])
						IDE_LBA0: lba_d[7:0]   = wb_s1;
						IDE_LBA1: lba_d[15:8]  = wb_s1;
						IDE_LBA2: lba_d[23:16] = wb_s1;
						IDE_LBA3: lba_d[27:24] = wb_s1[3:0];
						IDE_CMD:  req = (wb_s1 == IDE_CMD_READ);
						default: ;
					endcase
				end
			end
			MODE_READ: begin
				if (port_s1[7:5] == GRP_SERIAL) begin
					unique case (port_s1[1:0])
						SER_A_DATA: begin
							cha_ptr_d = '0;
							if (flevel != '0) begin
								rd        = fhead;
								fctrl.pop = 1'b1;
							end
						end
						SER_A_CTRL: begin
							cha_ptr_d = '0;
							rd = {7'd0, (cha_ptr_q == '0) && (flevel != '0)};
						end
						default: chb_ptr_d = '0;
					endcase
				end else if (port_s1[7:5] == GRP_IDE) begin
					if (port_s1[2:0] == IDE_DATA) begin
						rd = disk_s1;
					end else if (port_s1[2:0] == IDE_CMD) begin
						rd = IDE_STATUS_READY;
					end
				end
			end
			MODE_KEY: begin
				fctrl.push = (key_s1 < KEY_LIMIT) && (flevel != FULL);
			end
			default: ;
		endcase
		if (!step) begin
			fctrl.push = 1'b0;
			fctrl.pop  = 1'b0;
		end
	end

	always_comb begin
		level_after = flevel;
		if (fctrl.push) begin
			level_after = flevel + 1'b1;
		end else if (fctrl.pop) begin
			level_after = flevel - 1'b1;
		end
	end

	assign level_ext = {9'd0, level_after};

	iopb_kfifo #(
		.KEY_FIFO_DEPTH(KEY_FIFO_DEPTH)
	) u_kfifo (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (fctrl),
		.head  (fhead),
		.level (flevel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cha_ptr_q <= '0;
			chb_ptr_q <= '0;
			lba_q     <= '0;
			bank_q    <= 1'b0;
			vmode_q   <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (step) begin
				cha_ptr_q <= cha_ptr_d;
				chb_ptr_q <= chb_ptr_d;
				lba_q     <= lba_d;
				bank_q    <= bank_d;
				vmode_q   <= vmode_d;
				out_v_q   <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= {3'd0, level_ext[8:0], req, lba_d, vmode_d, bank_d, rd};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> s_tready)
		else $error("input stalled with empty result register");

	a_req_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q[43] |-> out_q[7:0] == 8'h00)
		else $error("sector request with read data");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_v_q |=> out_v_q)
		else $error("request did not advance");

endmodule
